@@ sv/pwt_pkg.sv @@
// press window timer bank: shared types and constants
// no dependencies
`default_nettype none

package pwt_pkg;

    localparam int OP_W         = 3;
    localparam int BUTTON_W     = 16;
    localparam int DELTA_W      = 16;
    localparam int INDEX_W      = 5;
    localparam int MASK_W       = 16;
    localparam int REM_W        = 16;
    localparam int WINDOW_W     = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_INDEX_W  = 1;

    localparam logic [WINDOW_W-1:0]    WINDOW_RESET     = 16'd60;
    localparam logic [REG_INDEX_W-1:0] REG_WINDOW_TICKS = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE    = 3'd0,
        OP_BUFFER    = 3'd1,
        OP_CONSUME   = 3'd2,
        OP_CLEAR_ONE = 3'd3,
        OP_CLEAR_ALL = 3'd4
    } pwt_op_e;

    // per-lane command for one request
    typedef struct packed {
        logic update;
        logic load;
        logic clear;
    } lane_ctrl_t;

    typedef struct packed {
        logic              ok;
        logic [MASK_W-1:0] buffered_mask;
        logic [REM_W-1:0]  remaining_ticks;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/pwt_req_if.sv @@
// request channel of the press window timer bank
// depends on pwt_pkg
`default_nettype none

interface pwt_req_if;
    logic                            valid;
    logic                            ready;
    logic [pwt_pkg::OP_W-1:0]        op;
    logic [pwt_pkg::BUTTON_W-1:0]    current_buttons;
    logic [pwt_pkg::BUTTON_W-1:0]    previous_buttons;
    logic [pwt_pkg::DELTA_W-1:0]     delta_ticks;
    logic [pwt_pkg::INDEX_W-1:0]     action_index;

    modport source (
        output valid, op, current_buttons, previous_buttons, delta_ticks, action_index,
        input  ready
    );

    modport sink (
        input  valid, op, current_buttons, previous_buttons, delta_ticks, action_index,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/pwt_rsp_if.sv @@
// response channel of the press window timer bank
// depends on pwt_pkg
`default_nettype none

interface pwt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [pwt_pkg::MASK_W-1:0]   buffered_mask;
    logic [pwt_pkg::REM_W-1:0]    remaining_ticks;

    modport source (
        output valid, ok, buffered_mask, remaining_ticks,
        input  ready
    );

    modport sink (
        input  valid, ok, buffered_mask, remaining_ticks,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/press_window_timer_bank.sv @@
// Bank of retriggerable one-shot countdown timers, one lane per action. Each request
// (update, buffer, consume, clear one, clear all) gets a registered response; a new
// request can be taken every cycle while the skid entry is empty. All lanes subtract
// and compare in parallel; a two-entry output stage (output register plus skid)
// keeps the request side open while one response waits. window_ticks is written over
// the APB port at address 0.
`default_nettype none

module press_window_timer_bank #(
    parameter int NUM_ACTIONS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pwt_req_if.sink                                req,
    pwt_rsp_if.source                              rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pwt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pwt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [pwt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import pwt_pkg::*;

    localparam int CW = (TIMER_BITS > WINDOW_W) ? TIMER_BITS : WINDOW_W;

    logic [WINDOW_W-1:0]    window_reg;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [CW-1:0]          window_w;
    logic [TIMER_BITS-1:0]  load_value;
    logic                   accept;
    logic                   ready;
    logic [BUTTON_W-1:0]    rise;
    logic [NUM_ACTIONS-1:0] sel;
    logic [NUM_ACTIONS-1:0] busy;
    logic [TIMER_BITS-1:0]  timer_next [NUM_ACTIONS];
    lane_ctrl_t             ctrl [NUM_ACTIONS];

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_index == REG_WINDOW_TICKS)
        begin
            window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    assign prdata = (reg_index == REG_WINDOW_TICKS) ? APB_DATA_W'(window_reg) : '0;

    // saturate the window to the timer range
    assign window_w   = CW'(window_reg);
    assign load_value = (window_w > CW'({TIMER_BITS{1'b1}})) ? {TIMER_BITS{1'b1}}
                                                             : window_w[TIMER_BITS-1:0];

    assign req.ready = ready;
    assign accept    = req.valid & ready;
    assign rise      = req.current_buttons & ~req.previous_buttons;

    genvar g;
    generate
        for (g = 0; g < NUM_ACTIONS; g++)
        begin : g_lane
            logic rise_bit;

            if (g < BUTTON_W)
            begin : g_btn
                assign rise_bit = rise[g];
            end
            else
            begin : g_nobtn
                assign rise_bit = 1'b0;
            end

            assign sel[g] = (req.action_index == INDEX_W'(g));

            always_comb
            begin
                ctrl[g] = '0;
                case (req.op)
                    OP_UPDATE:
                    begin
                        ctrl[g].update = 1'b1;
                        ctrl[g].load   = rise_bit;
                    end
                    OP_BUFFER:    ctrl[g].load  = sel[g];
                    OP_CONSUME:   ctrl[g].clear = sel[g];
                    OP_CLEAR_ONE: ctrl[g].clear = sel[g];
                    OP_CLEAR_ALL: ctrl[g].clear = 1'b1;
                    default:      ctrl[g] = '0;
                endcase
            end

            pwt_lane #(
                .TIMER_BITS (TIMER_BITS)
            ) u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (accept),
                .ctrl       (ctrl[g]),
                .load_value (load_value),
                .delta      (req.delta_ticks),
                .timer_next (timer_next[g]),
                .busy       (busy[g])
            );
        end
    endgenerate

    pwt_merge #(
        .NUM_ACTIONS (NUM_ACTIONS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (req.op),
        .sel        (sel),
        .busy       (busy),
        .timer_next (timer_next),
        .ready      (ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

@@ sv/pwt_lane.sv @@
// one countdown timer lane: subtract and expire, reload, clear
// depends on pwt_pkg
`default_nettype none

module pwt_lane #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire pwt_pkg::lane_ctrl_t           ctrl,
    input  wire logic [TIMER_BITS-1:0]         load_value,
    input  wire logic [pwt_pkg::DELTA_W-1:0]   delta,
    output logic      [TIMER_BITS-1:0]         timer_next,
    output logic                               busy
);
    import pwt_pkg::*;

    localparam int CW = (TIMER_BITS > DELTA_W) ? TIMER_BITS : DELTA_W;

    logic [TIMER_BITS-1:0] timer_reg;
    logic [CW-1:0]         timer_w;
    logic [CW-1:0]         delta_w;
    logic [TIMER_BITS-1:0] counted;

    assign timer_w = CW'(timer_reg);
    assign delta_w = CW'(delta);
    assign busy    = |timer_reg;

    always_comb
    begin
        if (delta == '0)
        begin
            counted = timer_reg;
        end
        else if (timer_w <= delta_w)
        begin
            counted = '0;
        end
        else
        begin
            counted = TIMER_BITS'(timer_w - delta_w);
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            timer_next = '0;
        end
        else if (ctrl.load)
        begin
            timer_next = load_value;
        end
        else if (ctrl.update)
        begin
            timer_next = counted;
        end
        else
        begin
            timer_next = timer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else if (en)
        begin
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/pwt_merge.sv @@
// merges lane results into one response, with output register and skid stage
// depends on pwt_pkg, pwt_rsp_if
`default_nettype none

module pwt_merge #(
    parameter int NUM_ACTIONS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [pwt_pkg::OP_W-1:0]    op,
    input  wire logic [NUM_ACTIONS-1:0]      sel,
    input  wire logic [NUM_ACTIONS-1:0]      busy,
    input  wire logic [TIMER_BITS-1:0]       timer_next [NUM_ACTIONS],
    output logic                             ready,
    pwt_rsp_if.source                        rsp
);
    import pwt_pkg::*;

    localparam int RW = (TIMER_BITS > REM_W) ? TIMER_BITS : REM_W;

    logic                  index_ok;
    logic                  sel_busy;
    logic [TIMER_BITS-1:0] rem_sel;
    logic [RW-1:0]         rem_w;
    logic [MASK_W-1:0]     mask;
    rsp_t                  result;
    rsp_t                  out_reg;
    rsp_t                  skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  pop;

    genvar g;
    generate
        for (g = 0; g < MASK_W; g++)
        begin : g_mask
            if (g < NUM_ACTIONS)
            begin : g_on
                assign mask[g] = |timer_next[g];
            end
            else
            begin : g_off
                assign mask[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        rem_sel = '0;
        for (int i = 0; i < NUM_ACTIONS; i++)
        begin
            rem_sel = rem_sel | (timer_next[i] & {TIMER_BITS{sel[i]}});
        end
    end

    assign index_ok = |sel;
    assign sel_busy = |(sel & busy);
    assign rem_w    = RW'(rem_sel);

    always_comb
    begin
        result.buffered_mask   = mask;
        result.remaining_ticks = (rem_w > RW'({REM_W{1'b1}})) ? {REM_W{1'b1}}
                                                              : rem_w[REM_W-1:0];
        case (op)
            OP_UPDATE:    result.ok = 1'b1;
            OP_BUFFER:    result.ok = index_ok;
            OP_CONSUME:   result.ok = sel_busy;
            OP_CLEAR_ONE: result.ok = index_ok;
            OP_CLEAR_ALL: result.ok = 1'b1;
            default:      result.ok = 1'b0;
        endcase
    end

    assign pop   = out_valid_reg & rsp.ready;
    assign ready = ~skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.ok              = out_reg.ok;
    assign rsp.buffered_mask   = out_reg.buffered_mask;
    assign rsp.remaining_ticks = out_reg.remaining_ticks;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_clear_all_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR_ALL && !out_valid_reg) |=>
        (rsp.valid && rsp.ok && rsp.buffered_mask == '0))
        else $error("clear all left a buffered action");

    a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_UPDATE && !out_valid_reg) |=> (rsp.valid && rsp.ok))
        else $error("update did not report success");
`endif

endmodule

`default_nettype wire
